// File: rtl/sspg_pkg.sv
// Package for the sequential servo pulse generator.
// Holds the shared constants, register indexes and item types.
// No dependencies.
package sspg_pkg;

	localparam int NumChannels = 8;
	localparam int ChanIdxW = 3;
	localparam int CursorW = 4;
	localparam int TickW = 16;
	localparam int WidthUsW = 15;

	localparam logic [CursorW-1:0] ChannelCountReset = 4'd0;
	localparam logic [TickW-1:0] FrameTopReset = 16'd40000;
	localparam logic [TickW-1:0] EmptySlotReset = 16'd1000;

	typedef enum logic [1:0] {
		CfgChannelCount = 2'd0,
		CfgFrameTop = 2'd1,
		CfgEmptySlot = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ActTick = 1'b0,
		ActSetWidth = 1'b1
	} action_t;

	typedef struct packed {
		logic [CursorW-1:0] channel_count;
		logic [TickW-1:0] frame_top;
		logic [TickW-1:0] empty_slot_ticks;
	} cfg_t;

	typedef struct packed {
		action_t action;
		logic [ChanIdxW-1:0] channel_index;
		logic [WidthUsW-1:0] width_us;
	} in_item_t;

	typedef struct packed {
		logic [NumChannels-1:0] servo_lines;
		logic [CursorW-1:0] active_channel;
		logic frame_start;
	} out_item_t;

endpackage

// File: rtl/sspg_seq.sv
// Frame counter, channel sequencer and width table of the servo pulse generator.
// Updates its state for one item per enabled cycle and gives that item's result.
// Depends on sspg_pkg.
module sspg_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  sspg_pkg::in_item_t item,
	input  sspg_pkg::cfg_t cfg,
	output sspg_pkg::out_item_t result
);

	logic [sspg_pkg::TickW-1:0] counter_q;
	logic [sspg_pkg::TickW-1:0] deadline_q;
	logic [sspg_pkg::CursorW-1:0] cursor_q;
	logic in_frame_q;
	logic [sspg_pkg::NumChannels-1:0] levels_q;
	logic [sspg_pkg::TickW-1:0] width_q [sspg_pkg::NumChannels];

	logic [sspg_pkg::TickW-1:0] counter_d;
	logic [sspg_pkg::TickW-1:0] deadline_d;
	logic [sspg_pkg::CursorW-1:0] cursor_d;
	logic in_frame_d;
	logic [sspg_pkg::NumChannels-1:0] levels_d;
	logic started;
	logic width_we;

	logic [sspg_pkg::CursorW-1:0] eff_count;
	logic [sspg_pkg::TickW:0] count_inc;
	logic wrap;
	logic [sspg_pkg::TickW-1:0] tick_count;
	logic deadline_hit;
	logic do_launch;
	logic [sspg_pkg::ChanIdxW-1:0] launch_ch;
	logic [sspg_pkg::ChanIdxW-1:0] drop_ch;
	logic [sspg_pkg::TickW-1:0] slot_raw;
	logic [sspg_pkg::TickW-1:0] slot_use;

	// Counts above the number of lines act as the number of lines.
	assign eff_count = (cfg.channel_count > sspg_pkg::CursorW'(sspg_pkg::NumChannels))
		? sspg_pkg::CursorW'(sspg_pkg::NumChannels) : cfg.channel_count;

	assign count_inc = {1'b0, counter_q} + {{sspg_pkg::TickW{1'b0}}, 1'b1};
	assign wrap = count_inc >= {1'b0, cfg.frame_top};
	assign tick_count = wrap ? '0 : count_inc[sspg_pkg::TickW-1:0];
	assign deadline_hit = !wrap && in_frame_q && (tick_count == deadline_q);

	assign launch_ch = wrap ? '0 : cursor_q[sspg_pkg::ChanIdxW-1:0];
	assign drop_ch = sspg_pkg::ChanIdxW'(cursor_q - sspg_pkg::CursorW'(1));
	assign slot_raw = width_q[launch_ch];
	assign slot_use = (slot_raw != '0) ? slot_raw : cfg.empty_slot_ticks;

	assign width_we = (item.action == sspg_pkg::ActSetWidth)
		&& ({1'b0, item.channel_index} < eff_count);

	always_comb begin
		counter_d = counter_q;
		deadline_d = deadline_q;
		cursor_d = cursor_q;
		in_frame_d = in_frame_q;
		levels_d = levels_q;
		started = 1'b0;
		do_launch = 1'b0;
		if (item.action == sspg_pkg::ActTick) begin
			counter_d = tick_count;
			if (wrap) begin
				started = 1'b1;
				levels_d = '0;
				cursor_d = '0;
				in_frame_d = eff_count != '0;
				do_launch = eff_count != '0;
			end else if (deadline_hit) begin
				if (cursor_q != '0) begin
					levels_d[drop_ch] = 1'b0;
				end
				if (cursor_q < eff_count) begin
					do_launch = 1'b1;
				end else begin
					cursor_d = '0;
					in_frame_d = 1'b0;
				end
			end
		end
		// A launched channel raises its line only for a nonzero width.
		if (do_launch) begin
			if (slot_raw != '0) begin
				levels_d[launch_ch] = 1'b1;
			end
			deadline_d = tick_count + slot_use;
			cursor_d = {1'b0, launch_ch} + sspg_pkg::CursorW'(1);
		end
	end

	assign result.servo_lines = levels_d;
	assign result.active_channel = cursor_d;
	assign result.frame_start = started;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			deadline_q <= '0;
			cursor_q <= '0;
			in_frame_q <= 1'b0;
			levels_q <= '0;
			for (int i = 0; i < sspg_pkg::NumChannels; i++) begin
				width_q[i] <= '0;
			end
		end else if (step_en) begin
			counter_q <= counter_d;
			deadline_q <= deadline_d;
			cursor_q <= cursor_d;
			in_frame_q <= in_frame_d;
			levels_q <= levels_d;
			if (width_we) begin
				width_q[item.channel_index] <= {item.width_us, 1'b0};
			end
		end
	end

endmodule

// File: rtl/sequential_servo_pulse_generator_top.sv
// Top level of the sequential servo pulse generator.
// Holds the configuration registers, input register and result register.
// Depends on sspg_pkg and sspg_seq.
//
// Usage:
// Each input item is either one timer tick (tuser = 0) or a width command
// (tuser = 1) that sets a channel's pulse width in microseconds. Every item
// gives exactly one result item: the servo line levels, the next channel to
// be handled and a frame start flag. Widths are stored as half-microsecond
// ticks; commands for channels at or above the channel count are dropped.
// An item's result is registered first in the input register and then in the
// result register, and the block takes one item every cycle while the receiver
// does not stall. The state update for an item is one combinational pass through
// the tick increment and compares, the width table read and the deadline add.
// When the receiver stalls, the result register and the input register both
// hold and s_axis_tready drops; no item is lost. Configuration writes are
// always taken (cfg_ready is high) and should only be issued while idle.
// Reset clears all lines, the frame counter, the width table and loads the
// default frame top of 40000 ticks and empty slot of 1000 ticks.
module sequential_servo_pulse_generator_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // channel_index[2:0], width_us[17:3], zero fill
	input  logic [0:0] s_axis_tuser,   // action[0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata,  // servo_lines[7:0], active_channel[11:8], zero fill
	output logic [0:0] m_axis_tuser,   // frame_start[0]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	sspg_pkg::cfg_t cfg_q;
	sspg_pkg::in_item_t item_s1;
	logic valid_s1;
	sspg_pkg::out_item_t res_q;
	logic res_valid_q;
	sspg_pkg::out_item_t step_result;
	logic advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= sspg_pkg::ChannelCountReset;
			cfg_q.frame_top <= sspg_pkg::FrameTopReset;
			cfg_q.empty_slot_ticks <= sspg_pkg::EmptySlotReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sspg_pkg::CfgChannelCount: cfg_q.channel_count <= cfg_data[sspg_pkg::CursorW-1:0];
				sspg_pkg::CfgFrameTop: cfg_q.frame_top <= cfg_data;
				sspg_pkg::CfgEmptySlot: cfg_q.empty_slot_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// Both stages move together whenever the result register is empty or being taken.
	assign advance = !res_valid_q || m_axis_tready;
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_axis_tvalid;
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1.action <= sspg_pkg::action_t'(s_axis_tuser[0]);
			item_s1.channel_index <= s_axis_tdata[sspg_pkg::ChanIdxW-1:0];
			item_s1.width_us <= s_axis_tdata[sspg_pkg::ChanIdxW +: sspg_pkg::WidthUsW];
			if (valid_s1) begin
				res_q <= step_result;
			end
		end
	end

	sspg_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance && valid_s1),
		.item(item_s1),
		.cfg(cfg_q),
		.result(step_result)
	);

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata = {4'd0, res_q.active_channel, res_q.servo_lines};
	assign m_axis_tuser = res_q.frame_start;

endmodule
